>>> hw/rtl/tdpt_pkg.sv
// Shared types and constants for the trial-division prime test unit.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package tdpt_pkg;

   // Result field widths and the packed response word
   localparam int unsigned COUNT_BITS    = 16;
   localparam int unsigned RSP_DATA_BITS = ((COUNT_BITS + 1 + 7) / 8) * 8;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Smallest prime, first trial divisor
   localparam int unsigned FIRST_DIVISOR = 2;

   // Request command codes
   localparam logic CMD_TEST  = 1'b0;
   localparam logic CMD_COUNT = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CHECK,
      ST_DIVIDE,
      ST_STEP,
      ST_RESULT,
      ST_FINISH
   } tdpt_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/trial_division_prime_test_unit.sv
// Trial-division prime test and prime counter, top level.
// Depends on tdpt_pkg; holds a bit-serial remainder unit and its sequencer.
//
//   channel | direction | ports                          | contents
//   --------+-----------+--------------------------------+-----------------------------
//   req     | in        | req_tvalid/tready/tdata/tuser  | value, command
//   rsp     | out       | rsp_tvalid/tready/tdata        | is_prime, prime_count
//
// Each trial divisor takes one bound check, a pass of the restoring remainder unit over
// all VALUE_BITS dividend bits (one dividend bit per cycle), and one divisor step.
// A count runs the prime test for every k in 2..value and tallies the primes.
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. Reset (synchronous) clears the sequencer and rsp_tvalid.
`default_nettype none

module trial_division_prime_test_unit
   import tdpt_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   localparam int ReqDataBits = ((VALUE_BITS + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [ReqDataBits-1:0]   req_tdata,   // [VALUE_BITS-1:0] value, rest zero
   input  wire logic                     req_tuser,   // [0] command
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata    // [0] is_prime, [16:1] prime_count
);

   localparam int SqBits  = VALUE_BITS + 2;
   localparam int CntBits = $clog2(VALUE_BITS);

   tdpt_state_type state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  mode_ff, mode_in;
   logic [VALUE_BITS-1:0] target_ff, target_in;
   logic [VALUE_BITS-1:0] k_ff, k_in;
   logic [VALUE_BITS-1:0] div_ff, div_in;
   logic [SqBits-1:0]     sq_ff, sq_in;
   logic [VALUE_BITS-1:0] shift_ff, shift_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [CntBits-1:0]    bit_cnt_ff, bit_cnt_in;
   logic                  prime_ff, prime_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_prime_ff, rsp_prime_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic [VALUE_BITS:0]   rem_shift;
   logic [VALUE_BITS:0]   rem_diff;

   // One restoring remainder step: bring down the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, shift_ff[VALUE_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      mode_in      = mode_ff;
      target_in    = target_ff;
      k_in         = k_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      prime_in     = prime_ff;
      count_in     = count_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_count_in = rsp_count_ff;
      req_tready   = 1'b0;

      // Drop the result once the transfer completes
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in   = req_tuser;
               target_in = req_tdata[VALUE_BITS-1:0];
               count_in  = '0;
               if (req_tuser == CMD_COUNT) begin
                  k_in = VALUE_BITS'(FIRST_DIVISOR);
                  if (req_tdata[VALUE_BITS-1:0] < VALUE_BITS'(FIRST_DIVISOR)) begin
                     prime_in = 1'b0;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_SETUP;
                  end
               end else begin
                  k_in     = req_tdata[VALUE_BITS-1:0];
                  state_in = ST_SETUP;
               end
            end
         end

         // Start a test of k with divisor 2
         ST_SETUP: begin
            div_in = VALUE_BITS'(FIRST_DIVISOR);
            sq_in  = SqBits'(FIRST_DIVISOR * FIRST_DIVISOR);
            if (k_ff < VALUE_BITS'(FIRST_DIVISOR)) begin
               prime_in = 1'b0;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_CHECK;
            end
         end

         // Stop once divisor squared exceeds k, else start a remainder pass
         ST_CHECK: begin
            if (sq_ff > SqBits'(k_ff)) begin
               prime_in = 1'b1;
               state_in = ST_RESULT;
            end else begin
               shift_in   = k_ff;
               rem_in     = '0;
               bit_cnt_in = CntBits'(VALUE_BITS - 1);
               state_in   = ST_DIVIDE;
            end
         end

         // Shift one dividend bit per cycle through the remainder
         ST_DIVIDE: begin
            shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
            if (rem_diff[VALUE_BITS]) begin
               rem_in = rem_shift[VALUE_BITS-1:0];
            end else begin
               rem_in = rem_diff[VALUE_BITS-1:0];
            end
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = ST_STEP;
            end
         end

         // Exact division means composite; otherwise advance divisor and its square
         ST_STEP: begin
            if (rem_ff == '0) begin
               prime_in = 1'b0;
               state_in = ST_RESULT;
            end else begin
               div_in   = div_ff + 1'b1;
               sq_in    = sq_ff + SqBits'({div_ff, 1'b1});
               state_in = ST_CHECK;
            end
         end

         // Tally a prime under counting, then move to the next k or finish
         ST_RESULT: begin
            if (mode_ff == CMD_COUNT && prime_ff && count_ff != COUNT_MAX) begin
               count_in = count_ff + 1'b1;
            end
            if (mode_ff == CMD_TEST || k_ff == target_ff) begin
               state_in = ST_FINISH;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_SETUP;
            end
         end

         // Hold until the output register is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      target_ff    <= target_in;
      k_ff         <= k_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      shift_ff     <= shift_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      prime_ff     <= prime_in;
      count_ff     <= count_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - COUNT_BITS - 1)'(0), rsp_count_ff, rsp_prime_ff};

endmodule

`default_nettype wire

>>> hw/rtl/tdpt_checker.sv
// Port-level checker for the trial-division prime test unit, and its bind.
// Depends on tdpt_pkg and on trial_division_prime_test_unit.
`default_nettype none

module tdpt_checker
   import tdpt_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   localparam int ReqDataBits = ((VALUE_BITS + 7) / 8) * 8
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tvalid,
   input wire logic                     req_tready,
   input wire logic [ReqDataBits-1:0]   req_tdata,
   input wire logic                     req_tuser,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Keep the padding above prime_count at zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_BITS-1:COUNT_BITS+1] == '0)
      else $error("response padding not zero");

   // Busy after a request transfer: one item in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A result never appears in the cycle right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early");

   // Reset clears the result channel
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind trial_division_prime_test_unit tdpt_checker #(.VALUE_BITS(VALUE_BITS)) u_tdpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> sim/prime_result_checker.sv
// Checker for the trial-division prime test unit: watches the request and response
// streams, predicts each response from the accepted request and compares it.
// Depends on tdpt_pkg for field widths, the count ceiling and the command codes.
module prime_result_checker
   import tdpt_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   parameter int REQ_BITS   = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [REQ_BITS-1:0]      req_tdata,   // [VALUE_BITS-1:0] value, rest zero
   input  wire logic                     req_tuser,   // [0] command
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic [RSP_DATA_BITS-1:0] rsp_tdata,   // [0] is_prime, [16:1] prime_count
   output int unsigned                   mismatches,
   output int unsigned                   outstanding,
   output int unsigned                   tests_seen,
   output int unsigned                   counts_seen,
   output int unsigned                   primes_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted response, with the request that caused it for reporting
   typedef struct packed {
      logic                  cmd;
      logic [VALUE_BITS-1:0] value;
      logic                  is_prime;
      logic [COUNT_BITS-1:0] prime_count;
   } verdict_type;

   verdict_type verdict_q[$];

   // Trial division, divisors from the first prime while d*d stays within n
   function automatic bit is_prime_trial(longint unsigned n);
      longint unsigned d;
      if (n < FIRST_DIVISOR) return 1'b0;
      for (d = FIRST_DIVISOR; d * d <= n; d++)
         if (n % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   // Count primes in 1..lim, saturating at the count ceiling
   function automatic logic [COUNT_BITS-1:0] primes_through(longint unsigned lim);
      longint unsigned k;
      logic [COUNT_BITS-1:0] total;
      total = '0;
      for (k = FIRST_DIVISOR; k <= lim; k++)
         if (is_prime_trial(k) && total != COUNT_MAX) total++;
      return total;
   endfunction

   function automatic verdict_type predict_verdict(logic cmd, logic [VALUE_BITS-1:0] value);
      verdict_type r;
      r.cmd         = cmd;
      r.value       = value;
      r.is_prime    = is_prime_trial(value);
      r.prime_count = (cmd == CMD_COUNT) ? primes_through(value) : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      verdict_type                           want;
      logic                                  got_prime;
      logic [COUNT_BITS-1:0]                 got_count;
      logic [RSP_DATA_BITS-COUNT_BITS-2:0]   got_pad;
      int unsigned                           errs;
      errs = 0;
      if (reset) begin
         verdict_q.delete();
         mismatches  <= 0;
         outstanding <= 0;
         tests_seen  <= 0;
         counts_seen <= 0;
         primes_seen <= 0;
      end else begin
         // compare each response transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_prime = rsp_tdata[0];
            got_count = rsp_tdata[COUNT_BITS:1];
            got_pad   = rsp_tdata[RSP_DATA_BITS-1:COUNT_BITS+1];
            if (verdict_q.size() == 0) begin
               $display("%0t: response %h with no request outstanding", $time, rsp_tdata);
               errs++;
            end else begin
               want = verdict_q.pop_front();
               if (got_prime !== want.is_prime) begin
                  $display("%0t: cmd %0d value %0d is_prime expected %0d actual %0d",
                           $time, want.cmd, want.value, want.is_prime, got_prime);
                  errs++;
               end
               if (got_count !== want.prime_count) begin
                  $display("%0t: cmd %0d value %0d prime_count expected %0d actual %0d",
                           $time, want.cmd, want.value, want.prime_count, got_count);
                  errs++;
               end
               if (got_pad !== '0) begin
                  $display("%0t: cmd %0d value %0d pad bits expected 0 actual %h",
                           $time, want.cmd, want.value, got_pad);
                  errs++;
               end
               if (got_prime === 1'b1) primes_seen <= primes_seen + 1;
            end
         end
         // predict the response of each request transfer
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(predict_verdict(req_tuser, req_tdata[VALUE_BITS-1:0]));
            if (req_tuser == CMD_COUNT) counts_seen <= counts_seen + 1;
            else tests_seen <= tests_seen + 1;
         end
         mismatches  <= mismatches + errs;
         outstanding <= unsigned'(verdict_q.size());
      end
   end

endmodule

>>> sim/tb_trial_division_prime_test_unit.sv
// Testbench top for the trial-division prime test unit: drives bursty requests and a
// stalling response side, and gives the verdict. Depends on tdpt_pkg, the unit itself
// and prime_result_checker, which predicts and compares every response.
module tb_trial_division_prime_test_unit
   import tdpt_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          VALUE_BITS      = 16;
   localparam int          REQ_BITS        = ((VALUE_BITS + 7) / 8) * 8;
   localparam int          CLOCK_PERIOD    = 12;
   localparam int unsigned IDLE_LIMIT      = 250000;
   localparam int unsigned STALL_CYCLES    = 2000;
   localparam int unsigned STALL_AFTER     = 3;
   localparam int unsigned DRAIN_CYCLES    = 64;
   localparam int unsigned RANDOM_ITEMS    = 122;
   localparam int unsigned SMALL_VALUE_MAX = 1023;
   localparam int unsigned COUNT_VALUE_MAX = 48;

   // Response-side stall patterns
   typedef enum int unsigned {RX_STEADY, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic [REQ_BITS-1:0]      req_tdata  = '0;
   logic                     req_tuser  = CMD_TEST;
   logic                     rsp_tready = 1'b0;
   logic                     req_tready;
   logic                     rsp_tvalid;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   int unsigned mismatches, outstanding, tests_seen, counts_seen, primes_seen;
   int unsigned rsp_beats   = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left  = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   trial_division_prime_test_unit #(.VALUE_BITS(VALUE_BITS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   prime_result_checker #(.VALUE_BITS(VALUE_BITS), .REQ_BITS(REQ_BITS)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .tests_seen  (tests_seen),
      .counts_seen (counts_seen),
      .primes_seen (primes_seen)
   );

   // Count response transfers to place the long stall
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) rsp_beats <= rsp_beats + 1;
   end

   // Watchdog: end the run once no transfer has happened for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, giving up", $time, IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request; bursts of random length separated by random gaps
   task automatic offer(input logic cmd, input logic [VALUE_BITS-1:0] value);
      if (burst_left == 0) begin
         if (req_tvalid) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata  <= REQ_BITS'($urandom());
            req_tuser  <= 1'($urandom_range(0, 1));
         end
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(negedge clock);
         else repeat ($urandom_range(0, 4)) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // Response side: switch stall patterns now and then, with one long hold-off
   initial begin : receiver
      rx_mode_type mode;
      int unsigned span;
      bit          held;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(8, 80);
         repeat (span) begin
            @(negedge clock);
            if (!held && rsp_beats >= STALL_AFTER) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (STALL_CYCLES) @(negedge clock);
            end
            case (mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned           pick;
      logic [VALUE_BITS-1:0] v;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // small values: 0 and 1 are not prime, 2 and 3 are, 4 is the first composite
      offer(CMD_TEST, 0);
      offer(CMD_TEST, 1);
      offer(CMD_TEST, 2);
      offer(CMD_TEST, 3);
      offer(CMD_TEST, 4);
      offer(CMD_TEST, 5);
      // squares of primes sit right on the divisor bound
      offer(CMD_TEST, 9);
      offer(CMD_TEST, 49);
      offer(CMD_TEST, 63001);
      // top of the value range: largest prime, all ones, single high bit
      offer(CMD_TEST, 65521);
      offer(CMD_TEST, 65535);
      offer(CMD_TEST, 32768);
      offer(CMD_TEST, 65534);
      // counting, from below the first prime up to a full byte
      offer(CMD_COUNT, 0);
      offer(CMD_COUNT, 1);
      offer(CMD_COUNT, 2);
      offer(CMD_COUNT, 3);
      offer(CMD_COUNT, 10);
      offer(CMD_COUNT, 100);
      offer(CMD_COUNT, 255);

      // random part: mostly tests, cheap or full-width, plus small counts
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            v = VALUE_BITS'($urandom_range(0, SMALL_VALUE_MAX));
            offer(CMD_TEST, v);
         end else if (pick < 75) begin
            v = VALUE_BITS'($urandom());
            offer(CMD_TEST, v);
         end else begin
            v = VALUE_BITS'($urandom_range(0, COUNT_VALUE_MAX));
            offer(CMD_COUNT, v);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain outstanding responses, then allow for stragglers
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d primality tests and %0d prime counts; %0d responses flagged prime.",
               tests_seen, counts_seen, primes_seen);
      $display("Requests came in bursts, responses under mixed stalls and one long hold-off.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> trial_division_prime_test_unit.f
hw/rtl/tdpt_pkg.sv
hw/rtl/trial_division_prime_test_unit.sv
hw/rtl/tdpt_checker.sv
sim/prime_result_checker.sv
sim/tb_trial_division_prime_test_unit.sv
